[rtl/core/uvc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package uvc_pkg;

  localparam int R_BITS   = 25;   // width of the reciprocal square root
  localparam int Q_BITS   = 7;    // quotient bits of the compress divide
  localparam int N_BITS   = 14;   // squared length of a code vector
  localparam int NUM_BITS = 22;   // |c| * 126
  localparam int SUM_BITS = 17;   // L1 norm
  localparam int P_BITS   = 63;
  localparam int QN_BITS  = 39;

  localparam logic FUNC_DECOMPRESS = 1'b0;
  localparam logic FUNC_COMPRESS   = 1'b1;

  typedef struct packed {
    logic                      func;
    logic [2:0]                neg;   // x, y, z result signs or code signs
    logic [2:0][6:0]           mag;   // x, y, z magnitudes of the code vector
    logic [N_BITS-1:0]         n;
    logic                      zero;
    logic [NUM_BITS-1:0]       numx;
    logic [NUM_BITS-1:0]       numy;
    logic [SUM_BITS-1:0]       sum;
  } uvc_item_t;

  typedef struct packed {
    uvc_item_t                 it;
    logic [P_BITS-1:0]         p;     // r*r*n
    logic [QN_BITS-1:0]        q;     // r*n
    logic [R_BITS-1:0]         r;
    logic [NUM_BITS-1:0]       remx;
    logic [NUM_BITS-1:0]       remy;
    logic [Q_BITS-1:0]         qx;
    logic [Q_BITS-1:0]         qy;
  } uvc_stage_t;

endpackage
`default_nettype wire

[rtl/core/uvc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module uvc_front import uvc_pkg::*; (
  input  wire logic               func,
  input  wire logic [15:0]        code_in,
  input  wire logic signed [15:0] x_in,
  input  wire logic signed [15:0] y_in,
  input  wire logic signed [15:0] z_in,
  output uvc_item_t               item
);

  logic [5:0]  cu;
  logic [6:0]  cv;
  logic [7:0]  uv_sum;
  logic [6:0]  u2, v2;
  logic signed [8:0] w;
  logic [6:0]  wm;
  logic        wneg;
  logic [16:0] ax, ay, az;

  always_comb begin
    cu     = code_in[12:7];
    cv     = code_in[6:0];
    uv_sum = {2'b0, cu} + {1'b0, cv};
    if (uv_sum >= 8'd127) begin
      u2 = 7'd127 - {1'b0, cu};
      v2 = 7'd127 - cv;
    end else begin
      u2 = {1'b0, cu};
      v2 = cv;
    end
    w    = 9'sd126 - $signed({2'b0, u2}) - $signed({2'b0, v2});
    wneg = w[8];
    wm   = wneg ? 7'd1 : w[6:0];

    ax = x_in[15] ? (17'd0 - {{1{x_in[15]}}, x_in}) : {1'b0, x_in};
    ay = y_in[15] ? (17'd0 - {{1{y_in[15]}}, y_in}) : {1'b0, y_in};
    az = z_in[15] ? (17'd0 - {{1{z_in[15]}}, z_in}) : {1'b0, z_in};

    item.func = func;
    item.mag  = {u2, v2, wm};
    item.n    = N_BITS'({7'd0, u2} * {7'd0, u2}) + N_BITS'({7'd0, v2} * {7'd0, v2})
              + N_BITS'({7'd0, wm} * {7'd0, wm});
    item.numx = NUM_BITS'(ax * 17'd126);
    item.numy = NUM_BITS'(ay * 17'd126);
    item.sum  = ax + ay + az;
    item.zero = (item.sum == '0);
    if (func == FUNC_COMPRESS) begin
      item.neg = {x_in[15], y_in[15], z_in[15]};
    end else begin
      item.neg = {code_in[15], code_in[14], code_in[13] ^ wneg};
    end
  end

endmodule
`default_nettype wire

[rtl/core/uvc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module uvc_queue import uvc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  uvc_item_t      push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           not_empty,
  output uvc_item_t      head
);

  uvc_item_t  mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_item;
  end

endmodule
`default_nettype wire

[rtl/core/uvc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module uvc_back import uvc_pkg::*; #(
  parameter int FRAC_BITS = 15
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  uvc_item_t          in_item,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [15:0]        code_out,
  output logic signed [15:0] x_out,
  output logic signed [15:0] y_out,
  output logic signed [15:0] z_out,
  output logic               zero_vector
);

  localparam int SH = 31 - FRAC_BITS;

  logic        en;
  uvc_stage_t  st  [R_BITS+1];
  uvc_stage_t  nxt [R_BITS];
  logic [R_BITS:0] vld;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    st[0].it   = in_item;
    st[0].p    = '0;
    st[0].q    = '0;
    st[0].r    = '0;
    st[0].remx = in_item.numx;
    st[0].remy = in_item.numy;
    st[0].qx   = '0;
    st[0].qy   = '0;
  end
  assign vld[0] = in_valid;

  // one root bit per stage, one quotient bit per stage in the first few
  for (genvar i = 0; i < R_BITS; i++) begin : g_stage
    localparam int K  = R_BITS - 1 - i;
    localparam int QB = (i < Q_BITS) ? (Q_BITS - 1 - i) : 0;
    logic [65:0] trial;
    logic [23:0] dsum;
    always_comb begin
      nxt[i] = st[i];
      trial  = {3'b0, st[i].p} + ({27'b0, st[i].q} << (K + 1))
             + ({52'b0, st[i].it.n} << (2 * K));
      if (trial <= (66'd1 << 62)) begin
        nxt[i].p    = trial[P_BITS-1:0];
        nxt[i].q    = st[i].q + QN_BITS'({25'b0, st[i].it.n} << K);
        nxt[i].r[K] = 1'b1;
      end
      dsum = '0;
      if (i < Q_BITS) begin
        dsum = {7'b0, st[i].it.sum} << QB;
        if ({2'b0, st[i].remx} >= dsum) begin
          nxt[i].remx = st[i].remx - dsum[NUM_BITS-1:0];
          nxt[i].qx[QB] = 1'b1;
        end
        if ({2'b0, st[i].remy} >= dsum) begin
          nxt[i].remy = st[i].remy - dsum[NUM_BITS-1:0];
          nxt[i].qy[QB] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) st[i+1] <= nxt[i];
    end
  end

  // multiply stage
  logic              m_vld;
  logic [2:0][32:0]  m_prod;
  logic              m_func, m_zero;
  logic [2:0]        m_neg;
  logic [15:0]       m_code;
  logic [6:0]        fu, fv;
  uvc_stage_t        ls;

  always_comb begin
    ls = st[R_BITS];
    fu = ls.qx;
    fv = ls.qy;
    if (ls.it.zero) begin
      fu = '0;
      fv = '0;
    end else if (ls.qx > 7'd63) begin
      fu = 7'd127 - ls.qx;
      fv = 7'd127 - ls.qy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (en) begin
      m_vld <= vld[R_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        m_prod[c] <= {26'b0, ls.it.mag[c]} * {8'b0, ls.r};
      end
      m_func <= ls.it.func;
      m_zero <= ls.it.zero;
      m_neg  <= ls.it.neg;
      m_code <= {ls.it.neg, fu[5:0], fv};
    end
  end

  // round, saturate, sign
  logic [2:0][15:0] comp;
  logic [33:0]      rnd;
  logic [33:0]      t;
  logic [15:0]      sat;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rnd = {1'b0, m_prod[c]} + (34'd1 << (SH - 1));
      t   = rnd >> SH;
      sat = (t > 34'd32767) ? 16'd32767 : t[15:0];
      comp[c] = m_neg[c] ? (16'd0 - sat) : sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (m_func == FUNC_COMPRESS) begin
        code_out    <= m_code;
        x_out       <= '0;
        y_out       <= '0;
        z_out       <= '0;
        zero_vector <= m_zero;
      end else begin
        code_out    <= '0;
        x_out       <= comp[2];
        y_out       <= comp[1];
        z_out       <= comp[0];
        zero_vector <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/unit_vector_16bit_codec.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel  handshake               payload
// input    in_valid / in_ready     func, code_in, x_in, y_in, z_in
// output   out_valid / out_ready   code_out, x_out, y_out, z_out, zero_vector
//
// one item per cycle sustained while the output is not stalled; an item passes
// the queue, 25 reciprocal square root stages (the first fed straight from the queue head),
// then multiply, then round into the output register
// the latency is set by the bit-per-stage root pipeline; the compress divide
// runs alongside in its first seven stages
// rst is synchronous and clears the queue and all stage valid bits
// a stalled output freezes the whole back pipeline; the two-entry queue keeps
// in_ready high for a while after the stall starts
module unit_vector_16bit_codec import uvc_pkg::*; #(
  parameter int COMPONENT_FRACTION_BITS = 15
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               func,
  input  wire logic [15:0]        code_in,
  input  wire logic signed [15:0] x_in,
  input  wire logic signed [15:0] y_in,
  input  wire logic signed [15:0] z_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             code_out,
  output logic signed [15:0]      x_out,
  output logic signed [15:0]      y_out,
  output logic signed [15:0]      z_out,
  output logic                    zero_vector
);

  uvc_item_t f_item;   // classified item from the front
  uvc_item_t q_head;
  logic      q_full, q_not_empty, b_ready;

  // front: unfold code or take abs and L1 norm of the vector
  uvc_front u_front (
    .func    (func),
    .code_in (code_in),
    .x_in    (x_in),
    .y_in    (y_in),
    .z_in    (z_in),
    .item    (f_item)
  );

  assign in_ready = !q_full;

  uvc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_item (f_item),
    .full      (q_full),
    .pop       (b_ready),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // back: root, divide, scale and round
  uvc_back #(
    .FRAC_BITS (COMPONENT_FRACTION_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (q_not_empty),
    .in_ready    (b_ready),
    .in_item     (q_head),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_out    (code_out),
    .x_out       (x_out),
    .y_out       (y_out),
    .z_out       (z_out),
    .zero_vector (zero_vector)
  );

endmodule
`default_nettype wire

[tb/sv/unit_vector_16bit_codec_tb.sv]
`timescale 1ns / 1ps
module unit_vector_16bit_codec_tb;
  import uvc_pkg::*;

  localparam int FRAC_BITS   = 15;
  localparam int STALL_LIMIT = 4000;   // cycles with no handshake at all
  localparam int TAIL_CYCLES = 60;     // well past the codec latency

  // one expected result item
  typedef struct {
    logic [15:0]        code;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               zero;
  } codec_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               func = FUNC_DECOMPRESS;
  logic [15:0]        code_in = '0;
  logic signed [15:0] x_in = '0;
  logic signed [15:0] y_in = '0;
  logic signed [15:0] z_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [15:0]        code_out;
  logic signed [15:0] x_out;
  logic signed [15:0] y_out;
  logic signed [15:0] z_out;
  logic               zero_vector;

  codec_result_t pending_results[$];
  int            mismatch_count = 0;
  int            quiet_cycles = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;

  always #2 clk = ~clk;

  unit_vector_16bit_codec #(
    .COMPONENT_FRACTION_BITS(FRAC_BITS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .code_in    (code_in),
    .x_in       (x_in),
    .y_in       (y_in),
    .z_in       (z_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_out   (code_out),
    .x_out      (x_out),
    .y_out      (y_out),
    .z_out      (z_out),
    .zero_vector(zero_vector)
  );

  // bit-serial integer square root, 64 bit
  function automatic longint unsigned int_sqrt(input longint unsigned val);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > val) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (val >= root + bitv) begin
        val  = val - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // reciprocal length of the code vector, scaled by 2^31
  function automatic longint unsigned recip_len(input logic [12:0] idx);
    int u, v, w, n;
    u = idx[12:7];
    v = idx[6:0];
    if (u + v >= 127) begin
      u = 127 - u;
      v = 127 - v;
    end
    w = 126 - u - v;
    n = u * u + v * v + w * w;
    if (n <= 0) n = 1;
    return int_sqrt((64'd1 << 62) / longint'(n));
  endfunction

  function automatic logic [15:0] scaled_component(input int c, input longint unsigned r,
                                                   input logic sign_bit);
    logic            neg;
    longint unsigned mag, t;
    neg = sign_bit;
    if (c < 0) begin
      neg = ~neg;
      mag = longint'(-c);
    end else begin
      mag = longint'(c);
    end
    t = (mag * r + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS);
    if (t > 32767) t = 32767;
    if (neg) t = 64'd0 - t;
    return t[15:0];
  endfunction

  function automatic int unsigned mag16(input logic [15:0] f);
    return f[15] ? (32'h10000 - f) : f;
  endfunction

  // expected result of one item, both operations
  function automatic codec_result_t codec_predict(input logic f, input logic [15:0] code,
                                                  input logic [15:0] x, input logic [15:0] y,
                                                  input logic [15:0] z);
    codec_result_t   res;
    int              u, v;
    longint unsigned r;
    int unsigned     ax, ay, az, sum, cu, cv;
    res = '{default: '0};
    if (f == FUNC_DECOMPRESS) begin
      u = code[12:7];
      v = code[6:0];
      r = recip_len(code[12:0]);
      if (u + v >= 127) begin
        u = 127 - u;
        v = 127 - v;
      end
      res.x = scaled_component(u, r, code[15]);
      res.y = scaled_component(v, r, code[14]);
      res.z = scaled_component(126 - u - v, r, code[13]);
    end else begin
      ax  = mag16(x);
      ay  = mag16(y);
      az  = mag16(z);
      sum = ax + ay + az;
      cu  = 0;
      cv  = 0;
      if (sum != 0) begin
        cu = (ax * 126) / sum;
        cv = (ay * 126) / sum;
        if (cu > 63) begin
          cu = 127 - cu;
          cv = 127 - cv;
        end
      end
      res.code = {x[15], y[15], z[15], cu[5:0], cv[6:0]};
      res.zero = (sum == 0);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatch_count++;
  endtask

  // sender; entered and left at a falling edge
  task automatic send_item(input logic f, input logic [15:0] code, input logic [15:0] x,
                           input logic [15:0] y, input logic [15:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    code_in  <= code;
    x_in     <= x;
    y_in     <= y;
    z_in     <= z;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(codec_predict(f, code, x, y, z));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // random receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin
    codec_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", code_out, 0);
      end else begin
        want = pending_results.pop_front();
        if (code_out !== want.code) report_mismatch("code_out", code_out, want.code);
        if (x_out !== want.x) report_mismatch("x_out", x_out, want.x);
        if (y_out !== want.y) report_mismatch("y_out", y_out, want.y);
        if (z_out !== want.z) report_mismatch("z_out", z_out, want.z);
        if (zero_vector !== want.zero) report_mismatch("zero_vector", zero_vector, want.zero);
      end
    end
  end

  // watchdog: no handshake on either side for too long while work is open
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (!in_valid && pending_results.size() == 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // directed decompress: extremes, fold boundary, full-scale axis
  task automatic test_decompress_edges();
    send_item(FUNC_DECOMPRESS, 16'h0000, 0, 0, 0);   // z axis, saturates
    send_item(FUNC_DECOMPRESS, 16'hffff, 0, 0, 0);
    send_item(FUNC_DECOMPRESS, 16'h1fc0, 0, 0, 0);   // u 63 v 64, folded with w -1
    send_item(FUNC_DECOMPRESS, 16'hffc0, 0, 0, 0);
    send_item(FUNC_DECOMPRESS, 16'h1fbf, 0, 0, 0);   // u 63 v 63, just unfolded
    send_item(FUNC_DECOMPRESS, 16'h007e, 0, 0, 0);   // y axis
    send_item(FUNC_DECOMPRESS, 16'h007f, 0, 0, 0);
    send_item(FUNC_DECOMPRESS, 16'ha000, 0, 0, 0);
    send_item(FUNC_DECOMPRESS, 16'h5555, 0, 0, 0);
    send_item(FUNC_DECOMPRESS, 16'h2aaa, 0, 0, 0);
  endtask

  // directed compress: zero vector, most negative, full scale, fold
  task automatic test_compress_edges();
    send_item(FUNC_COMPRESS, 0, 16'h0000, 16'h0000, 16'h0000);
    send_item(FUNC_COMPRESS, 0, 16'h8000, 16'h8000, 16'h8000);
    send_item(FUNC_COMPRESS, 0, 16'h7fff, 16'h7fff, 16'h7fff);
    send_item(FUNC_COMPRESS, 0, 16'h8000, 16'h0000, 16'h0000);
    send_item(FUNC_COMPRESS, 0, 16'h0000, 16'h7fff, 16'h0000);
    send_item(FUNC_COMPRESS, 0, 16'h0000, 16'h0000, 16'h8000);
    send_item(FUNC_COMPRESS, 0, 16'h7fff, 16'h0001, 16'hffff);
    send_item(FUNC_COMPRESS, 0, 16'h0001, 16'h0000, 16'h0000);
    send_item(FUNC_COMPRESS, 0, 16'hffff, 16'hffff, 16'h0001);
    send_item(FUNC_COMPRESS, 0, 16'h1234, 16'hedcc, 16'h0101);
  endtask

  function automatic logic [15:0] rand_component();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      2: return 16'($signed($urandom_range(16)) - 8);   // tiny vectors
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_random_items(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(1)) begin
        send_item(FUNC_COMPRESS, 16'($urandom), rand_component(), rand_component(),
                  rand_component());
      end else begin
        send_item(FUNC_DECOMPRESS, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 11;
    recv_idle_pct = 83;
    test_decompress_edges();
    test_compress_edges();
    test_random_items(330);
    // hold the sender until the pipe has fully drained
    wait_drained();
    @(negedge clk);

    send_idle_pct = 83;
    recv_idle_pct = 11;
    test_random_items(330);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_items(340);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/uvc_pkg.sv
rtl/core/uvc_front.sv
rtl/core/uvc_queue.sv
rtl/core/uvc_back.sv
rtl/core/unit_vector_16bit_codec.sv
tb/sv/unit_vector_16bit_codec_tb.sv
